// ===== rtl/cst_pkg.sv =====
package cst_pkg;

  localparam int unsigned NameLimit = 1023;
  localparam int unsigned NameLenW  = 10;
  localparam int unsigned PosW      = 32;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;
  // a byte produces at most two results
  localparam int unsigned MaxPush   = 2;

  typedef enum logic [20:0] {
    PH_IDLE       = 21'h000001,
    PH_SLASH      = 21'h000002,
    PH_LINE       = 21'h000004,
    PH_BLOCK      = 21'h000008,
    PH_BLOCK_STAR = 21'h000010,
    PH_NAME       = 21'h000020,
    PH_NUM        = 21'h000040,
    PH_SUF_U      = 21'h000080,
    PH_SUF_L      = 21'h000100,
    PH_OP         = 21'h000200,
    PH_SHIFT      = 21'h000400,
    PH_CH_OPEN    = 21'h000800,
    PH_CH_ESC     = 21'h001000,
    PH_CH_OCT     = 21'h002000,
    PH_CH_HEX     = 21'h004000,
    PH_CH_CLOSE   = 21'h008000,
    PH_STR        = 21'h010000,
    PH_STR_ESC    = 21'h020000,
    PH_STR_OCT    = 21'h040000,
    PH_STR_HEX    = 21'h080000,
    PH_STR_GAP    = 21'h100000
  } phase_e;

  localparam logic [6:0] K_ADD = 7'd0, K_SUB = 7'd1, K_MUL = 7'd2, K_DIV = 7'd3;
  localparam logic [6:0] K_INT = 7'd5, K_LPAR = 7'd7, K_RPAR = 7'd8, K_SEMI = 7'd9;
  localparam logic [6:0] K_END = 7'd10, K_ID = 7'd11, K_STR_END = 7'd12, K_COMMA = 7'd13;
  localparam logic [6:0] K_ASSIGN = 7'd14, K_MUL_EQ = 7'd15, K_DIV_EQ = 7'd16;
  localparam logic [6:0] K_MOD_EQ = 7'd17, K_ADD_EQ = 7'd18, K_SUB_EQ = 7'd19;
  localparam logic [6:0] K_SHL_EQ = 7'd20, K_SHR_EQ = 7'd21, K_AND_EQ = 7'd22;
  localparam logic [6:0] K_XOR_EQ = 7'd23, K_OR_EQ = 7'd24, K_QUEST = 7'd25;
  localparam logic [6:0] K_COLON = 7'd26, K_LOR = 7'd27, K_LAND = 7'd28, K_OR = 7'd29;
  localparam logic [6:0] K_XOR = 7'd30, K_AND = 7'd31, K_EQ = 7'd32, K_NE = 7'd33;
  localparam logic [6:0] K_LT = 7'd34, K_GT = 7'd35, K_LE = 7'd36, K_GE = 7'd37;
  localparam logic [6:0] K_SHL = 7'd38, K_SHR = 7'd39, K_MOD = 7'd40, K_INC = 7'd41;
  localparam logic [6:0] K_DEC = 7'd42, K_TILDE = 7'd43, K_NOT = 7'd44, K_SIZEOF = 7'd45;
  localparam logic [6:0] K_DOT = 7'd46, K_ARROW = 7'd47, K_LBRK = 7'd48, K_RBRK = 7'd49;
  localparam logic [6:0] K_KW_BASE = 7'd51, K_LBRACE = 7'd83, K_RBRACE = 7'd84;
  localparam logic [6:0] K_CHAR = 7'd85, K_LONG = 7'd86, K_UINT = 7'd87;
  localparam logic [6:0] K_ULONG = 7'd88, K_SBYTE = 7'd89, K_ERR = 7'd90;

  localparam logic [2:0] E_NONE = 3'd0, E_OPEN_COMMENT = 3'd1, E_OPEN_STR = 3'd2;
  localparam logic [2:0] E_BAD_ESC = 3'd3, E_EMPTY_CHAR = 3'd4;

  localparam logic [1:0] B_DEC = 2'd0, B_OCT = 2'd1, B_HEX = 2'd2, B_ZERO = 2'd3;

  localparam logic [1:0] ES_SIMPLE = 2'd0, ES_OCT = 2'd1, ES_HEX = 2'd2, ES_BAD = 2'd3;
  localparam logic [1:0] ED_TAKEN = 2'd0, ED_DONE = 2'd1, ED_END = 2'd2, ED_BAD = 2'd3;

  localparam logic [7:0] CH_NL = 8'h0A, CH_TAB = 8'h09, CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22, CH_APOS = 8'h27, CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam int unsigned KwCount = 32;
  localparam int unsigned KwSizeofIdx = 22;

  // keyword text, right aligned: last letter in the low byte
  localparam logic [63:0] KW_TEXT [KwCount] = '{
    64'("auto"), 64'("break"), 64'("case"), 64'("char"), 64'("const"),
    64'("continue"), 64'("default"), 64'("do"), 64'("double"), 64'("else"),
    64'("enum"), 64'("extern"), 64'("float"), 64'("for"), 64'("goto"), 64'("if"),
    64'("int"), 64'("long"), 64'("register"), 64'("return"), 64'("short"),
    64'("signed"), 64'("sizeof"), 64'("static"), 64'("struct"), 64'("switch"),
    64'("typedef"), 64'("union"), 64'("unsigned"), 64'("void"), 64'("volatile"),
    64'("while")
  };
  localparam logic [3:0] KW_LEN [KwCount] = '{
    4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2, 4'd6, 4'd4, 4'd4, 4'd6, 4'd5,
    4'd3, 4'd4, 4'd2, 4'd3, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
    4'd7, 4'd5, 4'd8, 4'd4, 4'd8, 4'd5
  };

  typedef struct packed {
    phase_e        ph;
    logic [63:0]   npre;
    logic [NameLenW-1:0] nlen;
    logic [63:0]   nval;
    logic [1:0]    nbase;
    logic [7:0]    pend;
    logic [7:0]    ev;
    logic [1:0]    ed;
    logic [PosW-1:0] sl;
    logic [PosW-1:0] sc;
    logic [2:0]    err;
  } st_t;

  localparam st_t StReset = '{ph: PH_IDLE, npre: '0, nlen: '0, nval: '0, nbase: B_DEC,
                              pend: '0, ev: '0, ed: '0, sl: PosW'(1), sc: PosW'(1),
                              err: E_NONE};

  typedef struct packed {
    logic [6:0]      kind;
    logic [63:0]     value;
    logic [PosW-1:0] line;
    logic [PosW-1:0] col;
    logic [2:0]      err;
  } res_t;

  typedef struct packed {
    res_t res;
    logic last;
  } out_item_t;

  typedef struct packed {
    st_t  s;
    logic emit;
    res_t res;
    logic again;
  } pass_t;

  typedef struct packed {
    logic [1:0] code;
    logic [7:0] val;
    logic [1:0] dig;
  } esc_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hexd_t;

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic hexd_t hex_val(logic [7:0] b);
    hexd_t h;
    h.ok = 1'b1;
    if (is_digit(b)) h.val = 4'(b - "0");
    else if (b >= "a" && b <= "f") h.val = 4'(b - "a" + 8'd10);
    else if (b >= "A" && b <= "F") h.val = 4'(b - "A" + 8'd10);
    else begin
      h.ok = 1'b0;
      h.val = '0;
    end
    return h;
  endfunction

  function automatic logic [6:0] name_kind(logic [63:0] pre, logic [NameLenW-1:0] len);
    logic [6:0] k;
    logic       m;
    k = K_ID;
    for (int i = 0; i < KwCount; i++) begin
      m = (len == NameLenW'(KW_LEN[i]));
      for (int j = 0; j < 8; j++) begin
        if (j < int'(KW_LEN[i]) &&
            pre[8*j +: 8] != KW_TEXT[i][8*(int'(KW_LEN[i]) - 1 - j) +: 8]) m = 1'b0;
      end
      if (m) k = (i == KwSizeofIdx) ? K_SIZEOF : K_KW_BASE + 7'(i);
    end
    return k;
  endfunction

  function automatic logic [6:0] op_single(logic [7:0] p);
    case (p)
      "+": return K_ADD;
      "-": return K_SUB;
      "*": return K_MUL;
      "<": return K_LT;
      ">": return K_GT;
      "=": return K_ASSIGN;
      "!": return K_NOT;
      "%": return K_MOD;
      "&": return K_AND;
      "^": return K_XOR;
      "|": return K_OR;
      default: return K_ADD;
    endcase
  endfunction

  // returns {match, kind}
  function automatic logic [7:0] op_pair(logic [7:0] p, logic [7:0] b);
    if (b == "=") begin
      case (p)
        "+": return {1'b1, K_ADD_EQ};
        "-": return {1'b1, K_SUB_EQ};
        "*": return {1'b1, K_MUL_EQ};
        "<": return {1'b1, K_LE};
        ">": return {1'b1, K_GE};
        "=": return {1'b1, K_EQ};
        "!": return {1'b1, K_NE};
        "%": return {1'b1, K_MOD_EQ};
        "&": return {1'b1, K_AND_EQ};
        "^": return {1'b1, K_XOR_EQ};
        "|": return {1'b1, K_OR_EQ};
        default: return '0;
      endcase
    end
    if (p == "+" && b == "+") return {1'b1, K_INC};
    if (p == "-" && b == "-") return {1'b1, K_DEC};
    if (p == "-" && b == ">") return {1'b1, K_ARROW};
    if (p == "&" && b == "&") return {1'b1, K_LAND};
    if (p == "|" && b == "|") return {1'b1, K_LOR};
    return '0;
  endfunction

  function automatic esc_t esc_start(logic [7:0] b, logic [7:0] ev);
    esc_t e;
    e.code = ES_SIMPLE;
    e.val  = ev;
    e.dig  = 2'd0;
    if (b >= "0" && b <= "7") begin
      e.code = ES_OCT;
      e.val  = b - "0";
      e.dig  = 2'd1;
    end else begin
      case (b)
        CH_BSLASH: e.val = 8'd92;
        CH_QUOTE:  e.val = 8'd34;
        CH_APOS:   e.val = 8'd39;
        "a":       e.val = 8'd7;
        "b":       e.val = 8'd8;
        "f":       e.val = 8'd12;
        "n":       e.val = 8'd10;
        "r":       e.val = 8'd13;
        "t":       e.val = 8'd9;
        "v":       e.val = 8'd11;
        "?":       e.val = 8'd63;
        "x": begin
          e.code = ES_HEX;
          e.val  = 8'd0;
        end
        default:   e.code = ES_BAD;
      endcase
    end
    return e;
  endfunction

  function automatic esc_t esc_digit(logic [7:0] ev, logic [1:0] ed, logic [7:0] b,
                                     logic hex);
    esc_t  e;
    hexd_t h;
    h = hex_val(b);
    e.val  = ev;
    e.dig  = ed;
    e.code = ED_TAKEN;
    if (hex) begin
      if (!h.ok) e.code = (ed == 2'd0) ? ED_BAD : ED_END;
      else begin
        e.val  = {ev[3:0], h.val};
        e.dig  = ed + 2'd1;
        e.code = (e.dig >= 2'd2) ? ED_DONE : ED_TAKEN;
      end
    end else if (b < "0" || b > "7") begin
      e.code = ED_END;
    end else begin
      e.val  = {ev[4:0], b[2:0]};
      e.dig  = ed + 2'd1;
      e.code = (e.dig >= 2'd3) ? ED_DONE : ED_TAKEN;
    end
    return e;
  endfunction

  function automatic pass_t put(pass_t p, logic [6:0] kind, logic [63:0] val);
    pass_t q;
    q = p;
    q.emit      = 1'b1;
    q.res.kind  = kind;
    q.res.value = val;
    q.res.line  = p.s.sl;
    q.res.col   = p.s.sc;
    q.res.err   = p.s.err;
    return q;
  endfunction

  function automatic pass_t fail(pass_t p, logic [2:0] code);
    pass_t q;
    q = p;
    q.s.err = code;
    q = put(q, K_ERR, 64'd0);
    q.s.ph = PH_IDLE;
    return q;
  endfunction

  // one step of the scanner for the current byte
  function automatic pass_t scan_pass(st_t s, logic [7:0] b, logic eof,
                                      logic [PosW-1:0] pl, logic [PosW-1:0] pc);
    pass_t      p;
    hexd_t      h;
    esc_t       e;
    logic       nc;
    logic [7:0] op;
    p.s     = s;
    p.emit  = 1'b0;
    p.res   = '0;
    p.again = 1'b0;
    h  = hex_val(b);
    nc = is_alpha(b) || is_digit(b) || b == CH_UNDER;
    op = eof ? 8'd0 : op_pair(s.pend, b);
    case (s.ph)
      PH_IDLE: begin
        p.s.sl = pl;
        p.s.sc = pc;
        if (eof) p = put(p, K_END, 64'd0);
        else if (is_alpha(b) || b == CH_UNDER) begin
          p.s.npre = {56'd0, b};
          p.s.nlen = NameLenW'(1);
          p.s.ph   = PH_NAME;
        end else if (is_digit(b)) begin
          p.s.nval  = {56'd0, b - "0"};
          p.s.nbase = (b == "0") ? B_ZERO : B_DEC;
          p.s.ph    = PH_NUM;
        end else begin
          case (b)
            "#":      p.s.ph = PH_LINE;
            "/":      p.s.ph = PH_SLASH;
            CH_APOS:  p.s.ph = PH_CH_OPEN;
            CH_QUOTE: p.s.ph = PH_STR;
            "+", "-", "*", "<", ">", "=", "!", "%", "&", "^", "|": begin
              p.s.pend = b;
              p.s.ph   = PH_OP;
            end
            "(": p = put(p, K_LPAR, 64'd0);
            ")": p = put(p, K_RPAR, 64'd0);
            ";": p = put(p, K_SEMI, 64'd0);
            ",": p = put(p, K_COMMA, 64'd0);
            "?": p = put(p, K_QUEST, 64'd0);
            ":": p = put(p, K_COLON, 64'd0);
            "~": p = put(p, K_TILDE, 64'd0);
            ".": p = put(p, K_DOT, 64'd0);
            "[": p = put(p, K_LBRK, 64'd0);
            "]": p = put(p, K_RBRK, 64'd0);
            "{": p = put(p, K_LBRACE, 64'd0);
            "}": p = put(p, K_RBRACE, 64'd0);
            default: ;
          endcase
        end
      end
      PH_SLASH: begin
        if (!eof && b == "/") p.s.ph = PH_LINE;
        else if (!eof && b == "*") p.s.ph = PH_BLOCK;
        else if (!eof && b == "=") begin
          p = put(p, K_DIV_EQ, 64'd0);
          p.s.ph = PH_IDLE;
        end else begin
          p = put(p, K_DIV, 64'd0);
          p.s.ph = PH_IDLE;
          p.again = 1'b1;
        end
      end
      PH_LINE: begin
        if (eof) begin
          p.s.ph = PH_IDLE;
          p.again = 1'b1;
        end else if (b == CH_NL) p.s.ph = PH_IDLE;
      end
      PH_BLOCK, PH_BLOCK_STAR: begin
        if (eof) p = fail(p, E_OPEN_COMMENT);
        else if (s.ph == PH_BLOCK_STAR && b == "/") p.s.ph = PH_IDLE;
        else p.s.ph = (b == "*") ? PH_BLOCK_STAR : PH_BLOCK;
      end
      PH_NAME: begin
        if (!eof && nc) begin
          if (s.nlen < NameLenW'(NameLimit)) begin
            if (s.nlen < NameLenW'(8)) p.s.npre = s.npre | ({56'd0, b} << {s.nlen[2:0], 3'b000});
            p.s.nlen = s.nlen + NameLenW'(1);
          end else begin
            // overlong name: cut here and start a new token
            p = put(p, name_kind(s.npre, s.nlen), 64'd0);
            p.s.sl   = pl;
            p.s.sc   = pc;
            p.s.npre = {56'd0, b};
            p.s.nlen = NameLenW'(1);
          end
        end else begin
          p = put(p, name_kind(s.npre, s.nlen), 64'd0);
          p.s.ph = PH_IDLE;
          p.again = 1'b1;
        end
      end
      PH_NUM: begin
        if (!eof && s.nbase == B_ZERO && (b == "x" || b == "X")) begin
          p.s.nbase = B_HEX;
          p.s.nval  = 64'd0;
        end else if (!eof && s.nbase == B_DEC && is_digit(b)) begin
          p.s.nval = (s.nval << 3) + (s.nval << 1) + {56'd0, b - "0"};
        end else if (!eof && s.nbase != B_DEC && s.nbase != B_HEX && b >= "0" && b <= "7") begin
          p.s.nbase = B_OCT;
          p.s.nval  = {s.nval[60:0], b[2:0]};
        end else if (!eof && s.nbase == B_HEX && h.ok) begin
          p.s.nval = {s.nval[59:0], h.val};
        end else if (!eof && (b == "u" || b == "U")) p.s.ph = PH_SUF_U;
        else if (!eof && (b == "l" || b == "L")) p.s.ph = PH_SUF_L;
        else begin
          p = put(p, K_INT, {32'd0, s.nval[31:0]});
          p.s.ph = PH_IDLE;
          p.again = 1'b1;
        end
      end
      PH_SUF_U: begin
        p.s.ph = PH_IDLE;
        if (!eof && (b == "l" || b == "L")) p = put(p, K_ULONG, s.nval);
        else begin
          p = put(p, K_UINT, {32'd0, s.nval[31:0]});
          p.again = 1'b1;
        end
      end
      PH_SUF_L: begin
        p.s.ph = PH_IDLE;
        if (!eof && (b == "u" || b == "U")) p = put(p, K_ULONG, s.nval);
        else begin
          p = put(p, K_LONG, s.nval);
          p.again = 1'b1;
        end
      end
      PH_OP: begin
        if (!eof && (s.pend == "<" || s.pend == ">") && b == s.pend) p.s.ph = PH_SHIFT;
        else begin
          p.s.ph = PH_IDLE;
          if (op[7]) p = put(p, op[6:0], 64'd0);
          else begin
            p = put(p, op_single(s.pend), 64'd0);
            p.again = 1'b1;
          end
        end
      end
      PH_SHIFT: begin
        p.s.ph = PH_IDLE;
        if (!eof && b == "=") p = put(p, (s.pend == "<") ? K_SHL_EQ : K_SHR_EQ, 64'd0);
        else begin
          p = put(p, (s.pend == "<") ? K_SHL : K_SHR, 64'd0);
          p.again = 1'b1;
        end
      end
      PH_CH_OPEN: begin
        if (eof) p = fail(p, E_OPEN_STR);
        else if (b == CH_BSLASH) p.s.ph = PH_CH_ESC;
        else if (b == CH_APOS) p = fail(p, E_EMPTY_CHAR);
        else begin
          p.s.ev = b;
          p.s.ph = PH_CH_CLOSE;
        end
      end
      PH_CH_ESC, PH_STR_ESC: begin
        if (eof) p = fail(p, E_OPEN_STR);
        else begin
          e = esc_start(b, s.ev);
          p.s.ev = e.val;
          p.s.ed = e.dig;
          case (e.code)
            ES_SIMPLE: begin
              if (s.ph == PH_CH_ESC) p.s.ph = PH_CH_CLOSE;
              else begin
                p = put(p, K_SBYTE, {56'd0, e.val});
                p.s.ph = PH_STR;
              end
            end
            ES_OCT:  p.s.ph = (s.ph == PH_CH_ESC) ? PH_CH_OCT : PH_STR_OCT;
            ES_HEX:  p.s.ph = (s.ph == PH_CH_ESC) ? PH_CH_HEX : PH_STR_HEX;
            default: p = fail(p, E_BAD_ESC);
          endcase
        end
      end
      PH_CH_OCT, PH_CH_HEX: begin
        if (eof) p = fail(p, E_OPEN_STR);
        else begin
          e = esc_digit(s.ev, s.ed, b, s.ph == PH_CH_HEX);
          p.s.ev = e.val;
          p.s.ed = e.dig;
          case (e.code)
            ED_TAKEN: ;
            ED_DONE:  p.s.ph = PH_CH_CLOSE;
            ED_END: begin
              // the byte is taken as the closing quote
              p = put(p, K_CHAR, {56'd0, e.val});
              p.s.ph = PH_IDLE;
            end
            default:  p = fail(p, E_BAD_ESC);
          endcase
        end
      end
      PH_CH_CLOSE: begin
        if (eof) p = fail(p, E_OPEN_STR);
        else begin
          p = put(p, K_CHAR, {56'd0, s.ev});
          p.s.ph = PH_IDLE;
        end
      end
      PH_STR: begin
        if (eof) p = fail(p, E_OPEN_STR);
        else if (b == CH_QUOTE) p.s.ph = PH_STR_GAP;
        else if (b == CH_BSLASH) p.s.ph = PH_STR_ESC;
        else p = put(p, K_SBYTE, {56'd0, b});
      end
      PH_STR_OCT, PH_STR_HEX: begin
        if (eof) p = fail(p, E_OPEN_STR);
        else begin
          e = esc_digit(s.ev, s.ed, b, s.ph == PH_STR_HEX);
          p.s.ev = e.val;
          p.s.ed = e.dig;
          case (e.code)
            ED_TAKEN: ;
            ED_DONE, ED_END: begin
              p = put(p, K_SBYTE, {56'd0, e.val});
              p.s.ph = PH_STR;
              p.again = (e.code == ED_END);
            end
            default: p = fail(p, E_BAD_ESC);
          endcase
        end
      end
      PH_STR_GAP: begin
        if (!eof && (b == CH_SPACE || b == CH_TAB || b == CH_NL)) ;
        else if (!eof && b == CH_QUOTE) p.s.ph = PH_STR;
        else begin
          p = put(p, K_STR_END, 64'd0);
          p.s.ph = PH_IDLE;
          p.again = 1'b1;
        end
      end
      default: begin
        p.s.ph = PH_IDLE;
        p.again = 1'b1;
      end
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/cst_if.sv =====
interface cst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, char_code, end_of_input, input ready);
  modport sink (input valid, char_code, end_of_input, output ready);
endinterface

interface cst_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  token_kind;
  logic [63:0] token_value;
  logic [31:0] start_row;
  logic [31:0] start_col;
  logic [2:0]  error_code;
  logic        last_of_run;

  modport source (output valid, token_kind, token_value, start_row, start_col,
                  error_code, last_of_run, input ready);
  modport sink (input valid, token_kind, token_value, start_row, start_col,
                error_code, last_of_run, output ready);
endinterface

// ===== rtl/c_source_tokenizer.sv =====
// C source tokenizer.
// in_i carries one source byte per item (char_code) or the end-of-input mark
// (end_of_input); out_o carries tokens with the line and column where each
// starts, the latched error code and a flag on the last token of a byte.
// Each accepted byte is scanned in the cycle it is taken; its tokens (zero,
// one or two) enter a four-entry result queue at that edge and are offered
// from that registered queue in order.
// Throughput is one byte per cycle while each byte yields at most one token
// and the receiver keeps up; a byte yielding two tokens adds both to the
// queue, which drains one token at a time. in_i.ready is high while the
// queue has room for two tokens, so with a stalled receiver input halts
// once three or more tokens wait and nothing is dropped.
// Reset clears the scanner to the between-tokens phase, line and column to
// one, the error latch and the queue. After an error token no further
// tokens come until reset; bytes are still accepted and dropped.
module c_source_tokenizer
  import cst_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  cst_in_if.sink    in_i,
  cst_out_if.source out_o
);

  st_t             st_q, st_d;
  logic [PosW-1:0] line_q, line_d, col_q, col_d;
  out_item_t       fifo_q [FifoDepth];
  logic [FifoPtrW-1:0] rd_q, wr_q;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic            acc, pop, use2, live;
  pass_t           p1, p2;
  logic [1:0]      npush;
  res_t            r0, r1;
  logic            e1, e2;

  assign acc  = in_i.valid && in_i.ready;
  assign pop  = out_o.valid && out_o.ready;
  assign live = (st_q.err == E_NONE);

  always_comb begin
    p1   = scan_pass(st_q, in_i.char_code, in_i.end_of_input, line_q, col_q);
    use2 = p1.again && (p1.s.err == E_NONE);
    p2   = scan_pass(p1.s, in_i.char_code, in_i.end_of_input, line_q, col_q);
    st_d = use2 ? p2.s : p1.s;
    e1   = p1.emit;
    e2   = use2 && p2.emit;
    r0   = e1 ? p1.res : p2.res;
    r1   = p2.res;
    npush = (acc && live) ? {1'b0, e1} + {1'b0, e2} : 2'd0;

    line_d = line_q;
    col_d  = col_q;
    if (!in_i.end_of_input) begin
      if (in_i.char_code == CH_NL) begin
        if (line_q != '1) line_d = line_q + PosW'(1);
        col_d = PosW'(1);
      end else if (col_q != '1) begin
        col_d = col_q + PosW'(1);
      end
    end
    cnt_d = cnt_q + FifoCntW'(npush) - FifoCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StReset;
      line_q      <= PosW'(1);
      col_q       <= PosW'(1);
      rd_q        <= '0;
      wr_q        <= '0;
      cnt_q       <= '0;
    end else begin
      if (acc && live) begin
        st_q   <= st_d;
        line_q <= line_d;
        col_q  <= col_d;
      end
      if (pop) rd_q <= rd_q + FifoPtrW'(1);
      wr_q  <= wr_q + FifoPtrW'(npush);
      cnt_q <= cnt_d;
    end
  end

  // result queue payload
  always_ff @(posedge clk_i) begin
    if (npush != 2'd0) begin
      fifo_q[wr_q] <= '{res: r0, last: (npush == 2'd1)};
    end
    if (npush == 2'd2) begin
      fifo_q[wr_q + FifoPtrW'(1)] <= '{res: r1, last: 1'b1};
    end
  end

  assign in_i.ready         = (cnt_q <= FifoCntW'(FifoDepth - MaxPush));
  assign out_o.valid        = (cnt_q != '0);
  assign out_o.token_kind   = fifo_q[rd_q].res.kind;
  assign out_o.token_value  = fifo_q[rd_q].res.value;
  assign out_o.start_row    = fifo_q[rd_q].res.line;
  assign out_o.start_col    = fifo_q[rd_q].res.col;
  assign out_o.error_code   = fifo_q[rd_q].res.err;
  assign out_o.last_of_run  = fifo_q[rd_q].last;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FifoCntW'(FifoDepth))
    else $error("result queue overfilled");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.err != E_NONE) |=> (st_q.err == $past(st_q.err)))
    else $error("error latch changed after an error");

  a_no_result_after_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.err != E_NONE) |=> (cnt_q <= $past(cnt_q)))
    else $error("token queued after an error");

  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> (line_q == $past(line_q)) && (col_q == $past(col_q)))
    else $error("position moved without an accepted byte");

endmodule
